FILE: src/pvc_pkg.sv
// Shared types and constants for the polygon validity checker.
`default_nettype none
package pvc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 32;
    localparam int MIN_VERTICES     = 3;

    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_TOO_FEW   = 3'd1;
    localparam logic [2:0] FAULT_COLLINEAR = 3'd2;
    localparam logic [2:0] FAULT_SELF_X    = 3'd3;
    localparam logic [2:0] FAULT_OVERFLOW  = 3'd4;

    localparam logic REG_TOLERANCE = 1'b0;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_EVAL,
        ST_PSEL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
    } t_cross_ctl;

    typedef struct packed {
        logic pos;
        logic below;
    } t_cross_flags;

endpackage
`default_nettype wire

FILE: src/pvc_vmem.sv
// Vertex store: one write port and one read port with registered read data.
`default_nettype none
module pvc_vmem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/pvc_cross.sv
// Exact cross product of three vertices read one after another, with sign and tolerance flags.
`default_nettype none
module pvc_cross
    import pvc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire t_cross_ctl                   i_ctl,
    input  wire logic signed [COORD_BITS-1:0] i_vx,
    input  wire logic signed [COORD_BITS-1:0] i_vy,
    input  wire logic [31:0]                  i_tol,
    output t_cross_flags                      o_flags
);

    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;
    localparam int CW    = PW + 1;
    localparam int CMP_W = CW + 32;

    logic signed [COORD_BITS-1:0] r_ax, r_ay;
    logic signed [DW-1:0]         r_dbx, r_dby, r_dcx, r_dcy;
    logic signed [PW-1:0]         r_p, r_q;
    logic signed [CW-1:0]         r_cr;
    logic [CW-1:0]                r_abs;
    logic                         r_pos;

    logic signed [DW-1:0] n_dx, n_dy;

    assign n_dx = DW'(i_vx) - DW'(r_ax);
    assign n_dy = DW'(i_vy) - DW'(r_ay);

    // The pipeline runs every cycle; the sequencer waits until the result of
    // the third vertex has passed through the product, difference and magnitude stages.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_a) begin
            r_ax <= i_vx;
            r_ay <= i_vy;
        end
        if (i_ctl.load_b) begin
            r_dbx <= n_dx;
            r_dby <= n_dy;
        end
        if (i_ctl.load_c) begin
            r_dcx <= n_dx;
            r_dcy <= n_dy;
        end
        r_p   <= PW'(r_dbx) * PW'(r_dcy);
        r_q   <= PW'(r_dby) * PW'(r_dcx);
        r_cr  <= CW'(r_p) - CW'(r_q);
        r_abs <= r_cr[CW-1] ? CW'(-r_cr) : CW'(r_cr);
        r_pos <= !r_cr[CW-1] && (|r_cr);
    end

    assign o_flags.pos   = r_pos;
    assign o_flags.below = CMP_W'(r_abs) < CMP_W'(i_tol);

endmodule
`default_nettype wire

FILE: src/polygon_validity_check.sv
// Top level of the polygon validity checker: stream ports, register port and check sequencer.
//
// Vertices are taken one per cycle into an on-chip vertex store. After the vertex flagged
// with tlast, the block runs its checks and accepts no new vertex until the verdict is
// queued in the output register. Each cross product goes through the single
// read port of the vertex store and the shared multiply pipeline: the collinear pass
// computes one cross product per vertex and each tested pair of non-adjacent edges
// takes four cross products and one pair-selection step; a fault ends the checks at once.
// A polygon with too few vertices or with more than MAX_VERTICES vertices is answered
// from the check state without any cross product.
`default_nettype none
module polygon_validity_check
    import pvc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] vertex_x, [63:32] vertex_y
    input  wire logic        s_axis_tlast,   // last_vertex
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [0] polygon_valid, [3:1] fault_code,
                                             // [10:4] vertex_total, [15:11] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int LW    = CNT_W + 1;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [LW-1:0]      r_i, n_i, r_j, n_j;
    logic [1:0]         r_k, n_k;
    logic [2:0]         r_step, n_step;
    logic               r_pair, n_pair;
    logic [3:0]         r_ori, n_ori;
    logic [2:0]         r_fault, n_fault;
    logic [31:0]        r_tol;
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_out_fault, n_out_fault;
    logic [6:0]         r_out_total, n_out_total;

    logic                      mem_we;
    logic [IDX_W-1:0]          mem_raddr;
    logic [2*COORD_BITS-1:0]   mem_rdata;
    logic [LW-1:0]             n_ext, idx_b, idx_c2, idx_d, t0, t1, t2, t_sel;
    logic                      in_acc, cross_now;
    t_cross_ctl                cross_ctl;
    t_cross_flags              flags;

    function automatic logic [LW-1:0] wrap_inc(input logic [LW-1:0] v, input logic [LW-1:0] n);
        logic [LW-1:0] s;
        s = v + LW'(1);
        return (s == n) ? '0 : s;
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOLERANCE) ? r_tol : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 32'd1;
        end else if (psel && penable && pwrite && (paddr[2] == REG_TOLERANCE)) begin
            r_tol <= pwdata;
        end
    end

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign mem_we = in_acc && (r_count < CNT_W'(MAX_VERTICES));

    pvc_vmem #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (2 * COORD_BITS)
    ) u_vmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({s_axis_tdata[32+COORD_BITS-1:32], s_axis_tdata[COORD_BITS-1:0]}),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign cross_ctl.load_a = (r_state == ST_EVAL) && (r_step == 3'd1);
    assign cross_ctl.load_b = (r_state == ST_EVAL) && (r_step == 3'd2);
    assign cross_ctl.load_c = (r_state == ST_EVAL) && (r_step == 3'd3);

    pvc_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk   (i_clk),
        .i_ctl   (cross_ctl),
        .i_vx    (mem_rdata[COORD_BITS-1:0]),
        .i_vy    (mem_rdata[2*COORD_BITS-1:COORD_BITS]),
        .i_tol   (r_tol),
        .o_flags (flags)
    );

    // Vertex indices of the triple that the current evaluation reads.
    assign n_ext  = LW'(r_count);
    assign idx_b  = wrap_inc(r_i, n_ext);
    assign idx_c2 = wrap_inc(idx_b, n_ext);
    assign idx_d  = wrap_inc(r_j, n_ext);

    always_comb begin
        t0 = r_i;
        t1 = idx_b;
        t2 = idx_c2;
        if (r_pair) begin
            case (r_k)
                2'd0: begin
                    t0 = r_i;   t1 = r_j;   t2 = idx_d;
                end
                2'd1: begin
                    t0 = idx_b; t1 = r_j;   t2 = idx_d;
                end
                2'd2: begin
                    t0 = r_i;   t1 = idx_b; t2 = r_j;
                end
                default: begin
                    t0 = r_i;   t1 = idx_b; t2 = idx_d;
                end
            endcase
        end
        case (r_step)
            3'd1:    t_sel = t1;
            3'd2:    t_sel = t2;
            default: t_sel = t0;
        endcase
    end

    assign mem_raddr = t_sel[IDX_W-1:0];
    assign cross_now = (r_ori[0] != r_ori[1]) && (r_ori[2] != flags.pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_step      <= n_step;
        r_pair      <= n_pair;
        r_ori       <= n_ori;
        r_fault     <= n_fault;
        r_out_fault <= n_out_fault;
        r_out_total <= n_out_total;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_step      = r_step;
        n_pair      = r_pair;
        n_ori       = r_ori;
        n_fault     = r_fault;
        n_out_valid = r_out_valid;
        n_out_fault = r_out_fault;
        n_out_total = r_out_total;
        s_axis_tready = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    if (mem_we) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                n_i    = '0;
                n_step = '0;
                n_pair = 1'b0;
                if (r_ovf) begin
                    n_fault = FAULT_OVERFLOW;
                    n_state = ST_EMIT;
                end else if (r_count < CNT_W'(MIN_VERTICES)) begin
                    n_fault = FAULT_TOO_FEW;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_step = '0;
                    if (!r_pair) begin
                        if (flags.below) begin
                            n_fault = FAULT_COLLINEAR;
                            n_state = ST_EMIT;
                        end else if (r_i == n_ext - LW'(1)) begin
                            n_pair  = 1'b1;
                            n_i     = '0;
                            n_j     = LW'(2);
                            n_state = ST_PSEL;
                        end else begin
                            n_i = r_i + LW'(1);
                        end
                    end else begin
                        n_ori[r_k] = flags.pos;
                        if (r_k != 2'd3) begin
                            n_k = r_k + 2'd1;
                        end else if (cross_now) begin
                            n_fault = FAULT_SELF_X;
                            n_state = ST_EMIT;
                        end else begin
                            n_j     = r_j + LW'(1);
                            n_state = ST_PSEL;
                        end
                    end
                end
            end
            ST_PSEL: begin
                if (r_i >= n_ext) begin
                    n_fault = FAULT_NONE;
                    n_state = ST_EMIT;
                end else if (r_j >= n_ext) begin
                    n_i = r_i + LW'(1);
                    n_j = r_i + LW'(3);
                end else if ((r_i == '0) && (r_j == n_ext - LW'(1))) begin
                    // The first and last edges share a vertex.
                    n_j = r_j + LW'(1);
                end else begin
                    n_k     = '0;
                    n_step  = '0;
                    n_state = ST_EVAL;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_fault = r_fault;
                    n_out_total = 7'(r_count);
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_total, r_out_fault, (r_out_fault == FAULT_NONE)};

endmodule
`default_nettype wire
